### src/utf8sv_pkg.sv
// Shared types and constants for the UTF-8 stream validator.
package utf8sv_pkg;

  // One byte of a string, with the end flag used in length mode.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  // One verdict per string.
  typedef struct packed {
    logic        string_ok;
    logic [31:0] good_prefix_bytes;
  } out_item_t;

  localparam int unsigned CODE_BITS = 21;

  localparam logic [CODE_BITS-1:0] CODE_LIMIT      = 21'h110000;
  localparam logic [CODE_BITS-1:0] SURR_MASK       = 21'h1FF800;
  localparam logic [CODE_BITS-1:0] SURR_BASE       = 21'h00D800;
  localparam logic [CODE_BITS-1:0] NONCHAR_LO      = 21'h00FDD0;
  localparam logic [CODE_BITS-1:0] NONCHAR_HI      = 21'h00FDEF;
  localparam logic [CODE_BITS-1:0] NONCHAR_END     = 21'h00FFFE;
  localparam logic [CODE_BITS-1:0] FLOOR_THREE     = 21'h000800;
  localparam logic [CODE_BITS-1:0] FLOOR_FOUR      = 21'h010000;

  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_TAG   = 8'h80;
  localparam logic [7:0] OVERLONG_2 = 8'h1E;

  // Sequence kind of an open three- or four-byte sequence.
  localparam logic KIND_THREE = 1'b0;
  localparam logic KIND_FOUR  = 1'b1;

  // True when a completed three- or four-byte value is a legal scalar value, not overlong and not a noncharacter.
  function automatic logic code_acceptable(input logic [CODE_BITS-1:0] v, input logic kind);
    logic [CODE_BITS-1:0] floor_v;
    logic                 ok;
    begin
      floor_v = (kind == KIND_FOUR) ? FLOOR_FOUR : FLOOR_THREE;
      ok = 1'b1;
      if (v < floor_v) ok = 1'b0;
      if (v >= CODE_LIMIT) ok = 1'b0;
      if ((v & SURR_MASK) == SURR_BASE) ok = 1'b0;
      if ((v >= NONCHAR_LO) && (v <= NONCHAR_HI)) ok = 1'b0;
      if ((v & NONCHAR_END) == NONCHAR_END) ok = 1'b0;
      return ok;
    end
  endfunction

endpackage

### src/utf8_stream_validator_unit.sv
// Top level of the UTF-8 stream validator: input stage, byte checker and result register.
//
// The block checks strings for well-formed UTF-8, one byte per request on the
// input channel (in_valid/in_ready, payload in_data). At the end of each string
// it gives one request on the result channel (out_valid/out_ready, payload
// out_data): string_ok, and the length of the valid prefix, which is the offset
// of the lead byte of the first bad sequence or the full length of a good string.
// The one configuration bit, stop_at_zero, must be written through cfg_we/cfg_wdata
// only while the block is idle; the block itself does not enforce this. When it is
// set a zero byte ends the string and is not counted; when it is clear the byte
// flagged by last_byte ends it and is counted. A byte enters the input stage register
// and is then checked and folded into the string state; a byte that ends a string
// loads the result register as it leaves the stage. One byte is taken per cycle,
// sustained, while no byte that ends a string waits for the result register.
// If the receiver stalls, bytes that do not end a string keep flowing; a byte
// that ends a string waits in the input stage until the result register frees.
// Reset (rst_n low, synchronous) empties both stages, clears the string state
// and sets stop_at_zero.
module utf8_stream_validator_unit #(
  parameter int unsigned OFFSET_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  utf8sv_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output utf8sv_pkg::out_item_t out_data,
  input  logic                  cfg_we,
  input  logic                  cfg_wdata
);
  import utf8sv_pkg::*;

  localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;

  // Configuration.
  logic stop_at_zero_r;

  // Input stage.
  logic     stg_valid_r;
  in_item_t stg_data_r;

  // String state.
  logic [1:0]             pend_r,     pend_nxt;
  logic [CODE_BITS-1:0]   code_r,     code_nxt;
  logic                   kind_r,     kind_nxt;
  logic                   two_r,      two_nxt;
  logic [OFFSET_BITS-1:0] lead_off_r, lead_off_nxt;
  logic [OFFSET_BITS-1:0] byte_off_r, byte_off_nxt;
  logic                   failed_r,   failed_nxt;
  logic [OFFSET_BITS-1:0] fail_off_r, fail_off_nxt;

  // Result register.
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r,  out_data_nxt;

  // Working values of the byte checker.
  logic [7:0]             b;
  logic                   end_zero;
  logic                   fin;
  logic                   advance;
  logic [1:0]             pend1;
  logic [CODE_BITS-1:0]   code1;
  logic [CODE_BITS-1:0]   code_cat;
  logic                   kind1;
  logic                   two1;
  logic [OFFSET_BITS-1:0] lead1;
  logic                   failed1;
  logic [OFFSET_BITS-1:0] fail_off1;
  logic [OFFSET_BITS-1:0] byte_off1;
  logic                   failed2;
  logic [OFFSET_BITS-1:0] count_sel;
  logic [63:0]            count_wide;

  assign b        = stg_data_r.data_byte;
  assign end_zero = stop_at_zero_r && (b == 8'h00);
  assign fin      = end_zero || (!stop_at_zero_r && stg_data_r.last_byte);

  // A byte that ends a string needs room in the result register; any other byte moves on.
  assign advance  = stg_valid_r && (!fin || !out_valid_r || out_ready);
  assign in_ready = !stg_valid_r || advance;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign code_cat = {code_r[CODE_BITS-7:0], b[5:0]};

  // Fold one byte into the sequence state. The terminating zero byte skips this.
  always_comb begin
    pend1     = pend_r;
    code1     = code_r;
    kind1     = kind_r;
    two1      = two_r;
    lead1     = lead_off_r;
    failed1   = failed_r;
    fail_off1 = fail_off_r;
    if (!end_zero && !failed_r) begin
      if (pend_r != 2'd0) begin
        if ((b & CONT_MASK) != CONT_TAG) begin
          // Bad continuation: the error belongs to the lead byte.
          failed1   = 1'b1;
          fail_off1 = lead_off_r;
          pend1     = 2'd0;
        end else begin
          code1 = code_cat;
          pend1 = pend_r - 2'd1;
          if ((pend_r == 2'd1) && !two_r && !code_acceptable(code_cat, kind_r)) begin
            failed1   = 1'b1;
            fail_off1 = lead_off_r;
          end
        end
      end else if (b[7]) begin
        lead1 = byte_off_r;
        two1  = 1'b0;
        if (b inside {[8'hC0:8'hDF]}) begin
          if ((b & OVERLONG_2) == 8'h00) begin
            failed1   = 1'b1;
            fail_off1 = byte_off_r;
          end else begin
            two1  = 1'b1;
            code1 = CODE_BITS'(b[4:0]);
            pend1 = 2'd1;
          end
        end else if (b inside {[8'hE0:8'hEF]}) begin
          kind1 = KIND_THREE;
          code1 = CODE_BITS'(b[3:0]);
          pend1 = 2'd2;
        end else if (b inside {[8'hF0:8'hF7]}) begin
          kind1 = KIND_FOUR;
          code1 = CODE_BITS'(b[2:0]);
          pend1 = 2'd3;
        end else begin
          // Stray continuation byte or a lead of F8 and above.
          failed1   = 1'b1;
          fail_off1 = byte_off_r;
        end
      end
    end
  end

  // Byte count, the end-of-string verdict and the saturated length.
  always_comb begin
    if (end_zero || (byte_off_r == OFFSET_MAX)) begin
      byte_off1 = byte_off_r;
    end else begin
      byte_off1 = byte_off_r + OFFSET_BITS'(1);
    end
    // A string that stops inside a sequence fails at that sequence's lead.
    failed2 = failed1 || (pend1 != 2'd0);
    if (failed1) begin
      count_sel = fail_off1;
    end else if (pend1 != 2'd0) begin
      count_sel = lead1;
    end else begin
      count_sel = byte_off1;
    end
    count_wide = 64'(count_sel);
  end

  // Next string state: the update above, or a clean slate once the string ends.
  always_comb begin
    pend_nxt     = pend_r;
    code_nxt     = code_r;
    kind_nxt     = kind_r;
    two_nxt      = two_r;
    lead_off_nxt = lead_off_r;
    byte_off_nxt = byte_off_r;
    failed_nxt   = failed_r;
    fail_off_nxt = fail_off_r;
    if (advance) begin
      if (fin) begin
        pend_nxt     = 2'd0;
        code_nxt     = '0;
        kind_nxt     = KIND_THREE;
        two_nxt      = 1'b0;
        lead_off_nxt = '0;
        byte_off_nxt = '0;
        failed_nxt   = 1'b0;
        fail_off_nxt = '0;
      end else begin
        pend_nxt     = pend1;
        code_nxt     = code1;
        kind_nxt     = kind1;
        two_nxt      = two1;
        lead_off_nxt = lead1;
        byte_off_nxt = byte_off1;
        failed_nxt   = failed1;
        fail_off_nxt = fail_off1;
      end
    end
  end

  // Result register loading.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (advance && fin) begin
      out_valid_nxt                  = 1'b1;
      out_data_nxt.string_ok         = !failed2;
      out_data_nxt.good_prefix_bytes = (|count_wide[63:32]) ? 32'hFFFF_FFFF : count_wide[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stop_at_zero_r <= 1'b1;
      stg_valid_r    <= 1'b0;
      out_valid_r    <= 1'b0;
      pend_r         <= 2'd0;
      code_r         <= '0;
      kind_r         <= KIND_THREE;
      two_r          <= 1'b0;
      lead_off_r     <= '0;
      byte_off_r     <= '0;
      failed_r       <= 1'b0;
      fail_off_r     <= '0;
    end else begin
      if (cfg_we) begin
        stop_at_zero_r <= cfg_wdata;
      end
      if (in_ready) begin
        stg_valid_r <= in_valid;
      end
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
      code_r      <= code_nxt;
      kind_r      <= kind_nxt;
      two_r       <= two_nxt;
      lead_off_r  <= lead_off_nxt;
      byte_off_r  <= byte_off_nxt;
      failed_r    <= failed_nxt;
      fail_off_r  <= fail_off_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stg_data_r <= in_data;
    end
    out_data_r <= out_data_nxt;
  end

  // Once a string has failed, no sequence stays open.
  a_fail_closes_seq : assert property (@(posedge clk) disable iff (!rst_n)
    failed_r |-> (pend_r == 2'd0))
    else $error("open sequence after a failure");

  // The failure offset never runs past the byte count.
  a_fail_off_bound : assert property (@(posedge clk) disable iff (!rst_n)
    failed_r |-> (fail_off_r <= byte_off_r))
    else $error("failure offset beyond byte count");

  // A finished string leaves a clean state and a pending result.
  a_end_clears : assert property (@(posedge clk) disable iff (!rst_n)
    (advance && fin) |=> ((byte_off_r == '0) && !failed_r && (pend_r == 2'd0) && out_valid_r))
    else $error("string state not cleared at end of string");

  // An empty input stage always takes a new request.
  a_ready_when_empty : assert property (@(posedge clk) disable iff (!rst_n)
    !stg_valid_r |-> in_ready)
    else $error("input stalled while stage empty");

endmodule

### tb/sv/utf8_stream_validator_unit_test.sv
// Self-checking testbench for the UTF-8 stream validator top level.
module utf8_stream_validator_unit_test;
  import utf8sv_pkg::*;

  // Run limits. The watchdog limit leaves a wide margin over the slowest correct run.
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned RANDOM_BYTES  = 1300;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned REPORT_LIMIT  = 10;
  localparam int unsigned LONG_HOLD     = 300;
  localparam int unsigned HOLD_STRINGS  = 60;

  // Values of the stop_at_zero register.
  localparam logic MODE_LENGTH = 1'b0;
  localparam logic MODE_ZERO   = 1'b1;

  // Shapes of a random string, and the ways a broken one is damaged.
  typedef enum int {SHAPE_CLEAN, SHAPE_BROKEN, SHAPE_NOISE} shape_t;
  typedef enum int {
    BREAK_REPLACE, BREAK_TRUNCATE, BREAK_STRAY, BREAK_OVERLONG, BREAK_RANGE, BREAK_LEAD
  } break_t;

  // Ready patterns of the result receiver.
  typedef enum int {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_PERIODIC} stall_t;

  // The verdict board tracks the string state the block should hold, works out
  // the verdict each accepted byte causes, and checks the verdicts the block gives.
  class utf8_verdict_board_t;
    out_item_t            verdicts_due[$];
    logic                 zero_mode;
    logic [1:0]           cont_left;
    logic [CODE_BITS-1:0] code_acc;
    logic                 four_byte;
    logic                 two_byte;
    logic [31:0]          lead_pos;
    logic [31:0]          byte_pos;
    logic [31:0]          fail_pos;
    logic                 seen_error;
    int unsigned          mismatches;
    int unsigned          results_checked;
    int unsigned          good_strings;
    int unsigned          bad_strings;

    function new();
      zero_mode       = MODE_ZERO;
      mismatches      = 0;
      results_checked = 0;
      good_strings    = 0;
      bad_strings     = 0;
      clear_string();
    endfunction

    function void clear_string();
      cont_left  = 2'd0;
      code_acc   = '0;
      four_byte  = KIND_THREE;
      two_byte   = 1'b0;
      lead_pos   = '0;
      byte_pos   = '0;
      fail_pos   = '0;
      seen_error = 1'b0;
    endfunction

    // Only the first error of a string sets the reported offset.
    function void mark_error(input logic [31:0] pos);
      if (!seen_error) begin
        seen_error = 1'b1;
        fail_pos   = pos;
      end
      cont_left = 2'd0;
    endfunction

    // A finished three- or four-byte value must be a scalar value that is
    // neither overlong, out of range, a surrogate nor a noncharacter.
    function logic scalar_ok(input logic [CODE_BITS-1:0] v, input logic four);
      logic [CODE_BITS-1:0] lowest;
      lowest = four ? 21'h010000 : 21'h000800;
      if (v < lowest || v >= 21'h110000) return 1'b0;
      if (v[20:11] == 10'h01B) return 1'b0;
      if (v >= 21'h00FDD0 && v <= 21'h00FDEF) return 1'b0;
      if (v[15:1] == 15'h7FFF) return 1'b0;
      return 1'b1;
    endfunction

    function void take_byte(input logic [7:0] b);
      if (seen_error) return;
      if (cont_left != 2'd0) begin
        // A bad continuation byte fails the open sequence and is not a new lead.
        if (b[7:6] != 2'b10) begin
          mark_error(lead_pos);
          return;
        end
        code_acc  = {code_acc[CODE_BITS-7:0], b[5:0]};
        cont_left = cont_left - 2'd1;
        if (cont_left == 2'd0 && !two_byte && !scalar_ok(code_acc, four_byte))
          mark_error(lead_pos);
        return;
      end
      if (!b[7]) return;
      lead_pos = byte_pos;
      two_byte = 1'b0;
      if (b[7:5] == 3'b110) begin
        if (b[4:1] == 4'd0) begin
          mark_error(byte_pos);
          return;
        end
        two_byte  = 1'b1;
        code_acc  = {16'd0, b[4:0]};
        cont_left = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
        four_byte = KIND_THREE;
        code_acc  = {17'd0, b[3:0]};
        cont_left = 2'd2;
      end else if (b[7:3] == 5'b11110) begin
        four_byte = KIND_FOUR;
        code_acc  = {18'd0, b[2:0]};
        cont_left = 2'd3;
      end else begin
        mark_error(byte_pos);
      end
    endfunction

    function void close_string();
      out_item_t v;
      if (cont_left != 2'd0) mark_error(lead_pos);
      v.string_ok         = !seen_error;
      v.good_prefix_bytes = seen_error ? fail_pos : byte_pos;
      verdicts_due.push_back(v);
      clear_string();
    endfunction

    // Called for every byte request the block accepts.
    function void note_request(input in_item_t item);
      if (zero_mode && item.data_byte == 8'h00) begin
        close_string();
        return;
      end
      take_byte(item.data_byte);
      if (byte_pos != '1) byte_pos = byte_pos + 32'd1;
      if (!zero_mode && item.last_byte) close_string();
    endfunction

    function void report(input string what, input logic [31:0] want, input logic [31:0] got);
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("verdict %0d: %s expected %0d, got %0d", results_checked, what, want, got);
    endfunction

    // Called for every verdict request the block hands over.
    function void check_result(input out_item_t got);
      out_item_t want;
      if (verdicts_due.size() == 0) begin
        report("verdict with none pending, prefix", 32'd0, got.good_prefix_bytes);
        return;
      end
      want = verdicts_due.pop_front();
      results_checked++;
      if (want.string_ok) good_strings++;
      else bad_strings++;
      if (got.string_ok !== want.string_ok)
        report("string_ok", {31'd0, want.string_ok}, {31'd0, got.string_ok});
      if (got.good_prefix_bytes !== want.good_prefix_bytes)
        report("good_prefix_bytes", want.good_prefix_bytes, got.good_prefix_bytes);
    endfunction
  endclass

  // Every input of the block starts at a known value.
  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic      cfg_we    = 1'b0;
  logic      cfg_wdata = 1'b0;

  utf8_verdict_board_t board;

  int unsigned cycle_count  = 0;
  int unsigned bytes_sent   = 0;
  int unsigned burst_left   = 0;
  int unsigned holds_asked  = 0;
  int unsigned holds_served = 0;
  int unsigned phase_count  = 0;

  // Bytes of the string that is about to be sent.
  logic [7:0] text[$];

  // Code points near the edges of the legal ranges, some of them illegal.
  int unsigned boundary_points [14] = '{
    'h7F, 'h80, 'h7FF, 'h800, 'hD7FF, 'hE000, 'hFDCF,
    'hFDD0, 'hFDF0, 'hFFFD, 'hFFFE, 'h10000, 'h1FFFF, 'h10FFFF
  };

  utf8_stream_validator_unit #(
    .OFFSET_BITS(32)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // The watchdog ends a run that hangs, for instance on a lost verdict.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("utf8_stream_validator_unit verification failed");
      $finish;
    end
  end

  // Verdict requests are checked at the edge that accepts them. Both sides are
  // read before the updates of that edge land, so the order of processes does
  // not matter.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) board.check_result(out_data);
  end

  // The receiver switches between ready patterns of random length. When the
  // stimulus asks for a hold-off, it keeps ready low for a long stretch, counted
  // here, so that the block fills up and stops taking bytes.
  stall_t      stall_style = READY_ALWAYS;
  int unsigned style_left  = 0;
  int unsigned hold_left   = 0;
  int unsigned pattern_step = 0;

  always @(posedge clk) begin
    if (holds_served != holds_asked) begin
      holds_served = holds_asked;
      hold_left    = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      if (style_left == 0) begin
        stall_style = stall_t'($urandom_range(0, 3));
        style_left  = $urandom_range(16, 96);
      end
      style_left--;
      pattern_step++;
      case (stall_style)
        READY_ALWAYS: begin
          out_ready <= 1'b1;
        end
        READY_COIN: begin
          out_ready <= 1'($urandom_range(0, 1));
        end
        READY_SPARSE: begin
          out_ready <= ($urandom_range(0, 3) == 0);
        end
        default: begin
          out_ready <= (pattern_step % 3 != 0);
        end
      endcase
    end
  end

  // Offers one byte request and returns at the edge that accepts it. The sender
  // works in bursts; between bursts valid drops for a random gap, and about a
  // third of the bursts follow the previous one with no gap at all. Valid is
  // only raised or lowered once per edge, so back-to-back requests keep it high.
  task automatic push_byte(input logic [7:0] b, input logic flag);
    int unsigned gap;
    in_item_t    item;
    item.data_byte = b;
    item.last_byte = flag;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= item;
    do begin
      @(posedge clk);
    end while (!in_ready);
    board.note_request(item);
    bytes_sent++;
  endtask

  // Stops offering bytes until every verdict has come back, then lets the
  // block's pipeline settle. Register writes only follow this.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (board.verdicts_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes stop_at_zero; the block is idle, so the board follows at once.
  task automatic write_mode(input logic mode);
    cfg_we    <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_we         <= 1'b0;
    board.zero_mode = mode;
  endtask

  // Sends the bytes in text as one string. In zero mode a zero byte follows and
  // the end flag is random noise; in length mode the flag marks the final byte.
  task automatic send_text(input logic mode);
    for (int i = 0; i < text.size(); i++)
      push_byte(text[i], (mode == MODE_ZERO) ? 1'($urandom_range(0, 1)) : (i == text.size() - 1));
    if (mode == MODE_ZERO) push_byte(8'h00, 1'($urandom_range(0, 1)));
  endtask

  // Appends the UTF-8 encoding of one code point to text.
  function automatic void put_scalar(input int unsigned cp);
    logic [20:0] v;
    v = 21'(cp);
    if (cp < 'h80) begin
      text.push_back(v[7:0]);
    end else if (cp < 'h800) begin
      text.push_back({3'b110, v[10:6]});
      text.push_back({2'b10, v[5:0]});
    end else if (cp < 'h10000) begin
      text.push_back({4'b1110, v[15:12]});
      text.push_back({2'b10, v[11:6]});
      text.push_back({2'b10, v[5:0]});
    end else begin
      text.push_back({5'b11110, v[20:18]});
      text.push_back({2'b10, v[17:12]});
      text.push_back({2'b10, v[11:6]});
      text.push_back({2'b10, v[5:0]});
    end
  endfunction

  // Random code point, weighted towards short sequences. Zero mode avoids the
  // zero byte so that the string is not cut short.
  function automatic int unsigned pick_scalar(input logic mode);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return (mode == MODE_ZERO) ? $urandom_range(1, 'h7F) : $urandom_range(0, 'h7F);
      4, 5:       return $urandom_range('h80, 'h7FF);
      6:          return $urandom_range('h800, 'hFFFF);
      7:          return $urandom_range('h10000, 'h10FFFF);
      default:    return boundary_points[$urandom_range(0, 13)];
    endcase
  endfunction

  function automatic logic [7:0] cont_byte();
    return 8'($urandom_range('h80, 'hBF));
  endfunction

  // Damages a well-formed string in one of several ways.
  function automatic void break_text(input logic mode);
    case (break_t'($urandom_range(0, 5)))
      BREAK_REPLACE: begin
        if (text.size() == 0) text.push_back(8'($urandom_range(0, 255)));
        else text[$urandom_range(0, text.size() - 1)] = 8'($urandom_range(0, 255));
      end
      BREAK_TRUNCATE: begin
        // A sequence cut short, sometimes followed by an ASCII byte that then
        // stands where a continuation byte should be.
        put_scalar($urandom_range('h80, 'h10FFFF));
        void'(text.pop_back());
        if ($urandom_range(0, 1) == 1) put_scalar($urandom_range(1, 'h7F));
      end
      BREAK_STRAY: begin
        text.insert($urandom_range(0, text.size()), cont_byte());
      end
      BREAK_OVERLONG: begin
        case ($urandom_range(0, 2))
          0: begin
            text.push_back(8'($urandom_range('hC0, 'hC1)));
            text.push_back(cont_byte());
          end
          1: begin
            text.push_back(8'hE0);
            text.push_back(8'($urandom_range('h80, 'h9F)));
            text.push_back(cont_byte());
          end
          default: begin
            text.push_back(8'hF0);
            text.push_back(8'($urandom_range('h80, 'h8F)));
            text.push_back(cont_byte());
            text.push_back(cont_byte());
          end
        endcase
      end
      BREAK_RANGE: begin
        if ($urandom_range(0, 1) == 1) begin
          text.push_back(8'hF4);
          text.push_back(8'($urandom_range('h90, 'hBF)));
        end else begin
          text.push_back(8'($urandom_range('hF5, 'hF7)));
          text.push_back(cont_byte());
        end
        text.push_back(cont_byte());
        text.push_back(cont_byte());
      end
      default: begin
        text.push_back(8'($urandom_range('hF8, 'hFF)));
      end
    endcase
    if ($urandom_range(0, 1) == 1) put_scalar(pick_scalar(mode));
  endfunction

  // Builds one random string: mostly well-formed text with random content,
  // some damaged text and some raw noise. A few strings are longer.
  function automatic void build_string(input logic mode);
    int unsigned count;
    int unsigned pick;
    shape_t      shape;
    text.delete();
    count = ($urandom_range(0, 7) == 0) ? $urandom_range(12, 30) : $urandom_range(0, 8);
    pick  = $urandom_range(0, 19);
    shape = (pick < 14) ? SHAPE_CLEAN : (pick < 18) ? SHAPE_BROKEN : SHAPE_NOISE;
    if (shape == SHAPE_NOISE) begin
      repeat (count + 1) text.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat (count) put_scalar(pick_scalar(mode));
      if (shape == SHAPE_BROKEN) break_text(mode);
    end
    // Length mode has no empty strings.
    if (mode == MODE_LENGTH && text.size() == 0) put_scalar($urandom_range(0, 'h7F));
  endfunction

  initial begin
    int unsigned random_goal;
    int unsigned phase_end;
    logic        mode;

    board = new();

    // Reset is applied once, at the start of the run.
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed strings in zero mode, the state after reset: the empty string,
    // the top ASCII byte, a C0 lead, a string that ends inside a sequence, and
    // a surrogate.
    text.delete();
    send_text(MODE_ZERO);
    text = '{8'h7F};
    send_text(MODE_ZERO);
    text = '{8'hC0, 8'hAF};
    send_text(MODE_ZERO);
    text = '{8'hE2, 8'h82};
    send_text(MODE_ZERO);
    text = '{8'hED, 8'hA0, 8'h80};
    send_text(MODE_ZERO);
    wait_drained();

    // Directed strings in length mode: a noncharacter, a value above the top
    // code point, a lead from F8 up, a zero byte as plain ASCII, a bad
    // continuation byte, and a stray continuation byte.
    write_mode(MODE_LENGTH);
    text = '{8'hEF, 8'hBF, 8'hBF};
    send_text(MODE_LENGTH);
    text = '{8'hF4, 8'h90, 8'h80, 8'h80};
    send_text(MODE_LENGTH);
    text = '{8'hFF};
    send_text(MODE_LENGTH);
    text = '{8'h00};
    send_text(MODE_LENGTH);
    text = '{8'hC3, 8'h41};
    send_text(MODE_LENGTH);
    text = '{8'h80};
    send_text(MODE_LENGTH);
    wait_drained();

    // Random phases. Each starts with a register write on an idle block and
    // ends with the sender waiting for every verdict. The first two phases use
    // both register values; the third runs under a long receiver hold-off with
    // a stream of short strings, so the block fills up and stalls its input.
    random_goal = bytes_sent + RANDOM_BYTES;
    while (bytes_sent < random_goal) begin
      if (phase_count == 0) mode = MODE_ZERO;
      else if (phase_count == 1) mode = MODE_LENGTH;
      else mode = 1'($urandom_range(0, 1));
      write_mode(mode);
      if (phase_count == 2) begin
        holds_asked++;
        repeat (HOLD_STRINGS) begin
          text.delete();
          put_scalar($urandom_range(1, 'h7F));
          send_text(mode);
        end
      end
      phase_end = bytes_sent + $urandom_range(100, 250);
      while (bytes_sent < phase_end) begin
        build_string(mode);
        send_text(mode);
      end
      wait_drained();
      phase_count++;
    end

    $display("Run covered %0d byte requests in %0d random phases and %0d verdicts",
             bytes_sent, phase_count, board.results_checked);
    $display("(%0d valid, %0d rejected), both stop conditions and a long receiver hold-off.",
             board.good_strings, board.bad_strings);
    if (board.mismatches == 0 && board.verdicts_due.size() == 0) begin
      $display("utf8_stream_validator_unit verification clean");
    end else begin
      $display("utf8_stream_validator_unit verification failed");
    end
    $finish;
  end

endmodule

### files.f
src/utf8sv_pkg.sv
src/utf8_stream_validator_unit.sv
tb/sv/utf8_stream_validator_unit_test.sv
